// ===== rtl/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbs_pkg
// Types, constants and helpers shared by the skinning unit and its channels.
// ---------------------------------------------------------------------------
package lbs_pkg;

  localparam int DefMaxJoints = 64;
  localparam int DefInfluences = 4;
  localparam int Slots = 12;
  localparam int PackedLanes = 4;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_SKIN = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [63:0]        weights_packed;
    logic [31:0]        bones_packed;
    logic [5:0]         entry_joint;
    logic [3:0]         entry_slot;
    logic signed [31:0] entry_value;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_nrm_x;
    logic signed [15:0] out_nrm_y;
    logic signed [15:0] out_nrm_z;
    logic               bad_bone;
  } lbs_out_t;

  // Matrix column of a slot (slot = column * 3 + row).
  function automatic logic [1:0] slot_col(input logic [3:0] slot);
    case (slot)
      4'd0, 4'd1, 4'd2:   slot_col = 2'd0;
      4'd3, 4'd4, 4'd5:   slot_col = 2'd1;
      4'd6, 4'd7, 4'd8:   slot_col = 2'd2;
      default:            slot_col = 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] slot_row(input logic [3:0] slot);
    case (slot)
      4'd0, 4'd3, 4'd6, 4'd9:  slot_row = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: slot_row = 2'd1;
      default:                 slot_row = 2'd2;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) sat32 = 32'sh7fffffff;
    else if (x < -52'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = 32'(x);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [51:0] x);
    if (x > 52'sd32767) sat16 = 16'sh7fff;
    else if (x < -52'sd32768) sat16 = 16'sh8000;
    else sat16 = 16'(x);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x > 50'sd140737488355327) sat48 = 48'sh7fffffffffff;
    else if (x < -50'sd140737488355328) sat48 = 48'sh800000000000;
    else sat48 = 48'(x);
  endfunction

endpackage

// ===== rtl/lbs_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbs_if
// Valid/ready channels for vertex/load items and skinned result items.
// ---------------------------------------------------------------------------
interface lbs_in_if import lbs_pkg::*; ();
  logic    valid;
  logic    ready;
  lbs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbs_out_if import lbs_pkg::*; ();
  logic     valid;
  logic     ready;
  lbs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/linear_blend_skinning_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_blend_skinning_unit
// Skins vertices against a joint matrix palette held in one synchronous RAM.
// ---------------------------------------------------------------------------
// A load item writes one palette word. A vertex item walks its lanes in
// turn; each weighted, in-palette lane reads its twelve matrix words through
// the single RAM read port, one word a cycle, through a multiply and an
// accumulate stage, then scales the three rows by the weight on two
// multipliers, one row a cycle. Lanes with a zero weight or an out-of-palette
// bone are skipped without reading the RAM. The result waits in an output
// register; the next item is taken while it waits.
module linear_blend_skinning_unit import lbs_pkg::*; #(
  parameter int MAX_JOINTS = DefMaxJoints,
  parameter int INFLUENCES = DefInfluences
) (
  input logic     clk,
  input logic     rst,
  lbs_in_if.sink  vtx,
  lbs_out_if.source res
);

  localparam int Depth = MAX_JOINTS * Slots;
  localparam int AW = $clog2(Depth);
  localparam int LW = $clog2(INFLUENCES + 1);

  typedef enum logic [2:0] {S_IDLE, S_LANE, S_READ, S_SCALE, S_DONE} state_t;

  state_t state;
  logic signed [31:0] palette [Depth];
  logic signed [31:0] rdata;

  lbs_in_t  cur;
  lbs_out_t out_reg;
  logic     out_valid;
  logic [LW-1:0] lane;
  logic [7:0]  bone;
  logic [15:0] wgt;
  logic [3:0]  slot;
  logic [1:0]  row;
  logic        bad;

  logic        s1_v;
  logic [3:0]  s1_slot;
  logic        s2_v;
  logic        s2_trans;
  logic [1:0]  s2_row;
  logic signed [31:0] s2_m;
  logic signed [63:0] prod_p;
  logic signed [47:0] prod_n;

  logic        t_v;
  logic [1:0]  t_row;
  logic signed [64:0] sp;
  logic signed [50:0] sn;

  logic signed [49:0] pacc [3];
  logic signed [49:0] nacc [3];
  logic signed [51:0] pos_acc [3];
  logic signed [51:0] nrm_acc [3];

  logic        acc_in;
  logic        is_load_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [3:0]  lane_ext;
  logic [15:0] lane_w;
  logic [7:0]  lane_b;
  logic signed [31:0] pos_sel;
  logic signed [15:0] nrm_sel;

  assign vtx.ready = (state == S_IDLE);
  assign acc_in = vtx.valid && vtx.ready;
  assign res.valid = out_valid;
  assign res.data = out_reg;

  assign is_load_ok = ({3'b0, vtx.data.entry_joint} < 9'(MAX_JOINTS))
                   && (vtx.data.entry_slot < 4'(Slots));
  assign wr_addr = AW'(14'(vtx.data.entry_joint) * 14'd12 + 14'(vtx.data.entry_slot));
  assign rd_addr = AW'(14'(bone) * 14'd12 + 14'(slot));

  assign lane_ext = 4'(lane);
  assign lane_w = (lane_ext < 4'(PackedLanes)) ?
                  cur.weights_packed[lane_ext[1:0]*16 +: 16] : 16'd0;
  assign lane_b = cur.bones_packed[lane_ext[1:0]*8 +: 8];

  always_comb begin
    case (slot_col(s1_slot))
      2'd0: begin
        pos_sel = cur.pos_x;
        nrm_sel = cur.nrm_x;
      end
      2'd1: begin
        pos_sel = cur.pos_y;
        nrm_sel = cur.nrm_y;
      end
      default: begin
        pos_sel = cur.pos_z;
        nrm_sel = cur.nrm_z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_in && vtx.data.func == FUNC_LOAD && is_load_ok) begin
      palette[wr_addr] <= vtx.data.entry_value;
    end
    rdata <= palette[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      t_v <= 1'b0;
    end else begin
      if (res.valid && res.ready) out_valid <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      t_v <= 1'b0;

      // Multiply stage.
      if (s1_v) begin
        s2_v <= 1'b1;
        s2_row <= slot_row(s1_slot);
        s2_trans <= (slot_col(s1_slot) == 2'd3);
        s2_m <= rdata;
        prod_p <= 64'(rdata) * 64'(pos_sel);
        prod_n <= 48'(rdata) * 48'(nrm_sel);
      end
      // Accumulate stage.
      if (s2_v) begin
        if (s2_trans) pacc[s2_row] <= pacc[s2_row] + 50'(s2_m);
        else begin
          pacc[s2_row] <= pacc[s2_row] + 50'(prod_p >>> 16);
          nacc[s2_row] <= nacc[s2_row] + 50'(prod_n);
        end
      end
      // Weight scale accumulate.
      if (t_v) begin
        pos_acc[t_row] <= pos_acc[t_row] + 52'(sp >>> 15);
        nrm_acc[t_row] <= nrm_acc[t_row] + 52'(sn >>> 15);
      end

      case (state)
        S_IDLE: begin
          if (acc_in && vtx.data.func == FUNC_SKIN) begin
            cur <= vtx.data;
            lane <= '0;
            bad <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              pos_acc[i] <= '0;
              nrm_acc[i] <= '0;
            end
            state <= S_LANE;
          end
        end
        S_LANE: begin
          if (lane == LW'(INFLUENCES)) begin
            state <= S_DONE;
          end else if (lane_w == 16'd0) begin
            lane <= lane + 1'b1;
          end else if ({1'b0, lane_b} >= 9'(MAX_JOINTS)) begin
            bad <= 1'b1;
            lane <= lane + 1'b1;
          end else begin
            bone <= lane_b;
            wgt <= lane_w;
            slot <= '0;
            for (int i = 0; i < 3; i++) begin
              pacc[i] <= '0;
              nacc[i] <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (slot < 4'(Slots)) begin
            s1_v <= 1'b1;
            s1_slot <= slot;
            slot <= slot + 1'b1;
          end else if (!s1_v && !s2_v) begin
            row <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (row != 2'd3) begin
            t_v <= 1'b1;
            t_row <= row;
            sp <= 65'($signed({1'b0, wgt})) * 65'(sat48(pacc[row]));
            sn <= 51'($signed({1'b0, wgt})) * 51'(nacc[row] >>> 16);
            row <= row + 1'b1;
          end else if (!t_v) begin
            lane <= lane + 1'b1;
            state <= S_LANE;
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_reg.out_pos_x <= sat32(pos_acc[0]);
            out_reg.out_pos_y <= sat32(pos_acc[1]);
            out_reg.out_pos_z <= sat32(pos_acc[2]);
            out_reg.out_nrm_x <= sat16(nrm_acc[0]);
            out_reg.out_nrm_y <= sat16(nrm_acc[1]);
            out_reg.out_nrm_z <= sat16(nrm_acc[2]);
            out_reg.bad_bone <= bad;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
